// ===== hdl/mwsasm_pkg.sv =====
package mwsasm_pkg;

   // Port width of every word field; WORD_BITS selects how much of it is used
   localparam int FIELD_BITS = 64;
   localparam int WORD_BITS_DEFAULT = 64;
   localparam int CMD_BITS = 3;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_ADD   = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_SUB   = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_RSUB  = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_CADD  = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_CSUB  = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_CSWAP = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_CNEG  = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_MUL   = 3'd7;

   // Result queue depth (power of two, room is kept for two writes)
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [FIELD_BITS-1:0] x_word;
      logic [FIELD_BITS-1:0] y_word;
      logic                  y_active;
      logic                  cond;
      logic                  first;
      logic                  last;
   } req_item_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] word_a;
      logic [FIELD_BITS-1:0] word_b;
      logic                  carry_out;
      logic                  underflow;
      logic                  last_out;
   } rsp_item_type;

endpackage

// ===== hdl/multiword_serial_add_sub_mul_top.sv =====
// Multiword carry-chain ALU: big integers stream through one word per item,
// least significant word first, and one running carry word links the words
// (add, subtract, reverse subtract, conditional add/subtract/swap/negate and
// multiply by a single word). An item is accepted every clock cycle unless the
// result queue is full; results pass stages s1, s2, s3. A multiply item marked
// last yields two results (low word, then the final carry word), so a stream
// of such items is limited by the result port at one result per cycle. The
// per-cycle limit is the carry loop through the final adder; the word multiply
// is split into four half-width products in a stage of its own.
module multiword_serial_add_sub_mul_top #(
   parameter int WORD_BITS = mwsasm_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mwsasm_pkg::CMD_BITS-1:0]     req_cmd,
   input  logic [mwsasm_pkg::FIELD_BITS-1:0]   req_x_word,
   input  logic [mwsasm_pkg::FIELD_BITS-1:0]   req_y_word,
   input  logic                                req_y_active,
   input  logic                                req_cond,
   input  logic                                req_first,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mwsasm_pkg::FIELD_BITS-1:0]   rsp_word_a,
   output logic [mwsasm_pkg::FIELD_BITS-1:0]   rsp_word_b,
   output logic                                rsp_carry_out,
   output logic                                rsp_underflow,
   output logic                                rsp_last_out
);

   localparam int HALF_LO = (WORD_BITS + 1) / 2;
   localparam int HALF_HI = WORD_BITS - HALF_LO;
   localparam int PROD_BITS = 2 * WORD_BITS;

   mwsasm_pkg::req_item_type req_item;
   mwsasm_pkg::req_item_type s1_item_ff;
   mwsasm_pkg::req_item_type s2_item_ff;
   mwsasm_pkg::req_item_type s3_item_ff;
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic s1_valid_in;
   logic s2_valid_in;
   logic s3_valid_in;
   logic s1_open;
   logic s2_open;
   logic s3_open;
   logic out_fire;
   logic fifo_room;

   logic [WORD_BITS-1:0]   mul_x;
   logic [WORD_BITS-1:0]   mul_y;
   logic [HALF_LO-1:0]     x_lo;
   logic [HALF_HI-1:0]     x_hi;
   logic [HALF_LO-1:0]     y_lo;
   logic [HALF_HI-1:0]     y_hi;
   logic [2*HALF_LO-1:0]   p00_in;
   logic [WORD_BITS-1:0]   p01_in;
   logic [WORD_BITS-1:0]   p10_in;
   logic [2*HALF_HI-1:0]   p11_in;
   logic [2*HALF_LO-1:0]   p00_ff;
   logic [WORD_BITS-1:0]   p01_ff;
   logic [WORD_BITS-1:0]   p10_ff;
   logic [2*HALF_HI-1:0]   p11_ff;
   logic [PROD_BITS-1:0]   prod_in;
   logic [PROD_BITS-1:0]   prod_ff;

   logic [WORD_BITS-1:0]   carry_ff;
   logic [WORD_BITS-1:0]   carry_next;
   mwsasm_pkg::rsp_item_type res_main;
   mwsasm_pkg::rsp_item_type res_extra;
   mwsasm_pkg::rsp_item_type rsp_item;
   logic                   extra_valid;

   // Input item
   always_comb begin
      req_item          = '0;
      req_item.cmd      = req_cmd;
      req_item.x_word   = req_x_word;
      req_item.y_word   = req_y_word;
      req_item.y_active = req_y_active;
      req_item.cond     = req_cond;
      req_item.first    = req_first;
      req_item.last     = req_last;
   end

   // Pipeline flow: a stage loads whenever it is empty or drains
   assign out_fire  = s3_valid_ff & fifo_room;
   assign s3_open   = ~s3_valid_ff | out_fire;
   assign s2_open   = ~s2_valid_ff | s3_open;
   assign s1_open   = ~s1_valid_ff | s2_open;
   assign req_ready = s1_open;

   always_comb begin
      s1_valid_in = s1_open ? req_valid : s1_valid_ff;
      s2_valid_in = s2_open ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = s3_open ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Half-width partial products of x times the raw y word
   assign mul_x  = s1_item_ff.x_word[WORD_BITS-1:0];
   assign mul_y  = s1_item_ff.y_word[WORD_BITS-1:0];
   assign x_lo   = mul_x[HALF_LO-1:0];
   assign x_hi   = mul_x[WORD_BITS-1:HALF_LO];
   assign y_lo   = mul_y[HALF_LO-1:0];
   assign y_hi   = mul_y[WORD_BITS-1:HALF_LO];
   assign p00_in = (2*HALF_LO)'(x_lo) * (2*HALF_LO)'(y_lo);
   assign p01_in = WORD_BITS'(x_lo) * WORD_BITS'(y_hi);
   assign p10_in = WORD_BITS'(x_hi) * WORD_BITS'(y_lo);
   assign p11_in = (2*HALF_HI)'(x_hi) * (2*HALF_HI)'(y_hi);

   // Partial products combined into the full double-width product
   assign prod_in = PROD_BITS'(p00_ff)
                  + (PROD_BITS'(p01_ff) << HALF_LO)
                  + (PROD_BITS'(p10_ff) << HALF_LO)
                  + (PROD_BITS'(p11_ff) << (2 * HALF_LO));

   // Stage payload registers
   always_ff @(posedge clock) begin
      if (s1_open) begin
         s1_item_ff <= req_item;
      end
      if (s2_open) begin
         s2_item_ff <= s1_item_ff;
         p00_ff     <= p00_in;
         p01_ff     <= p01_in;
         p10_ff     <= p10_in;
         p11_ff     <= p11_in;
      end
      if (s3_open) begin
         s3_item_ff <= s2_item_ff;
         prod_ff    <= prod_in;
      end
   end

   // Carry chain and command select
   mwsasm_alu #(
      .WORD_BITS (WORD_BITS)
   ) u_alu (
      .item        (s3_item_ff),
      .prod        (prod_ff),
      .carry_cur   (carry_ff),
      .res_main    (res_main),
      .res_extra   (res_extra),
      .extra_valid (extra_valid),
      .carry_next  (carry_next)
   );

   // Running carry word advances once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else if (out_fire) begin
         carry_ff <= carry_next;
      end
   end

   // Result queue decouples the result port from the pipeline
   mwsasm_fifo u_fifo (
      .clock         (clock),
      .reset         (reset),
      .wr_main       (out_fire),
      .wr_extra      (out_fire & extra_valid),
      .wr_data_main  (res_main),
      .wr_data_extra (res_extra),
      .room          (fifo_room),
      .rd_valid      (rsp_valid),
      .rd_ready      (rsp_ready),
      .rd_data       (rsp_item)
   );

   assign rsp_word_a    = rsp_item.word_a;
   assign rsp_word_b    = rsp_item.word_b;
   assign rsp_carry_out = rsp_item.carry_out;
   assign rsp_underflow = rsp_item.underflow;
   assign rsp_last_out  = rsp_item.last_out;

endmodule

// ===== hdl/mwsasm_alu.sv =====
module mwsasm_alu #(
   parameter int WORD_BITS = mwsasm_pkg::WORD_BITS_DEFAULT
) (
   input  mwsasm_pkg::req_item_type  item,
   input  logic [2*WORD_BITS-1:0]    prod,
   input  logic [WORD_BITS-1:0]      carry_cur,
   output mwsasm_pkg::rsp_item_type  res_main,
   output mwsasm_pkg::rsp_item_type  res_extra,
   output logic                      extra_valid,
   output logic [WORD_BITS-1:0]      carry_next
);

   logic [WORD_BITS-1:0]   x_w;
   logic [WORD_BITS-1:0]   y_raw;
   logic [WORD_BITS-1:0]   y_w;
   logic [WORD_BITS-1:0]   cin_word;
   logic                   cin;
   logic [WORD_BITS:0]     sum_xy;
   logic [WORD_BITS:0]     dif_xy;
   logic [WORD_BITS:0]     dif_yx;
   logic [WORD_BITS:0]     neg_x;
   logic [2*WORD_BITS-1:0] mac;
   logic [WORD_BITS-1:0]   a_w;
   logic [WORD_BITS-1:0]   b_w;
   logic                   co;
   logic                   uf;

   // Operand words, masked to the word width
   assign x_w   = item.x_word[WORD_BITS-1:0];
   assign y_raw = item.y_word[WORD_BITS-1:0];
   assign y_w   = item.y_active ? y_raw : '0;

   // Carry entering this word: restarted on the first word
   always_comb begin
      if (item.first) begin
         cin_word = (item.cmd == mwsasm_pkg::CMD_CNEG && item.cond) ?
                    WORD_BITS'(1) : '0;
      end else begin
         cin_word = carry_cur;
      end
   end
   assign cin = cin_word[0];

   // Carry chains, one bit wider than the word
   assign sum_xy = {1'b0, x_w} + {1'b0, y_w} + (WORD_BITS+1)'(cin);
   assign dif_xy = {1'b0, x_w} - {1'b0, y_w} - (WORD_BITS+1)'(cin);
   assign dif_yx = {1'b0, y_w} - {1'b0, x_w} - (WORD_BITS+1)'(cin);
   assign neg_x  = {1'b0, ~x_w} + (WORD_BITS+1)'(cin);

   // Multiply-accumulate: full carry word is added to the product
   assign mac = prod + (2*WORD_BITS)'(cin_word);

   // Command select
   always_comb begin
      a_w         = x_w;
      b_w         = '0;
      co          = 1'b0;
      uf          = 1'b0;
      carry_next  = '0;
      extra_valid = 1'b0;
      res_extra   = '0;
      case (item.cmd)
         mwsasm_pkg::CMD_ADD: begin
            a_w        = sum_xy[WORD_BITS-1:0];
            co         = sum_xy[WORD_BITS];
            carry_next = WORD_BITS'(sum_xy[WORD_BITS]);
         end
         mwsasm_pkg::CMD_SUB: begin
            a_w        = dif_xy[WORD_BITS-1:0];
            co         = dif_xy[WORD_BITS];
            carry_next = WORD_BITS'(dif_xy[WORD_BITS]);
         end
         mwsasm_pkg::CMD_RSUB: begin
            a_w        = dif_yx[WORD_BITS-1:0];
            co         = dif_yx[WORD_BITS];
            uf         = item.last & dif_yx[WORD_BITS];
            carry_next = WORD_BITS'(dif_yx[WORD_BITS]);
         end
         mwsasm_pkg::CMD_CADD: begin
            a_w        = item.cond ? sum_xy[WORD_BITS-1:0] : x_w;
            co         = item.cond & sum_xy[WORD_BITS];
            carry_next = WORD_BITS'(sum_xy[WORD_BITS]);
         end
         mwsasm_pkg::CMD_CSUB: begin
            a_w        = item.cond ? dif_xy[WORD_BITS-1:0] : x_w;
            co         = item.cond & dif_xy[WORD_BITS];
            carry_next = WORD_BITS'(dif_xy[WORD_BITS]);
         end
         mwsasm_pkg::CMD_CNEG: begin
            a_w        = item.cond ? neg_x[WORD_BITS-1:0] : x_w;
            co         = item.cond & neg_x[WORD_BITS];
            carry_next = WORD_BITS'(neg_x[WORD_BITS]);
         end
         mwsasm_pkg::CMD_CSWAP: begin
            a_w = item.cond ? y_w : x_w;
            b_w = item.cond ? x_w : y_w;
         end
         mwsasm_pkg::CMD_MUL: begin
            // Low half out now, high half carried; last word also flushes it
            a_w         = mac[WORD_BITS-1:0];
            carry_next  = mac[2*WORD_BITS-1:WORD_BITS];
            extra_valid = item.last;
            res_extra.word_a   = mwsasm_pkg::FIELD_BITS'(mac[2*WORD_BITS-1:WORD_BITS]);
            res_extra.last_out = 1'b1;
         end
         default: begin
            carry_next = '0;
         end
      endcase
   end

   // Main result item
   always_comb begin
      res_main           = '0;
      res_main.word_a    = mwsasm_pkg::FIELD_BITS'(a_w);
      res_main.word_b    = mwsasm_pkg::FIELD_BITS'(b_w);
      res_main.carry_out = co;
      res_main.underflow = uf;
      res_main.last_out  = item.last & ~extra_valid;
   end

endmodule

// ===== hdl/mwsasm_fifo.sv =====
module mwsasm_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_main,
   input  logic                     wr_extra,
   input  mwsasm_pkg::rsp_item_type wr_data_main,
   input  mwsasm_pkg::rsp_item_type wr_data_extra,
   output logic                     room,
   output logic                     rd_valid,
   input  logic                     rd_ready,
   output mwsasm_pkg::rsp_item_type rd_data
);

   localparam int PTR_BITS = $clog2(mwsasm_pkg::RSP_DEPTH);
   localparam int CNT_BITS = $clog2(mwsasm_pkg::RSP_DEPTH + 1);

   mwsasm_pkg::rsp_item_type mem_ff [mwsasm_pkg::RSP_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] wr_ptr_plus1;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic [1:0]          wr_count;
   logic                rd_fire;

   // Room is reserved for a two-item write
   assign room     = count_ff <= CNT_BITS'(mwsasm_pkg::RSP_DEPTH - 2);
   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign rd_fire  = rd_valid & rd_ready;

   assign wr_count     = {1'b0, wr_main} + {1'b0, wr_extra};
   assign wr_ptr_plus1 = wr_ptr_ff + PTR_BITS'(1);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(wr_count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(rd_fire);
      count_in  = count_ff + CNT_BITS'(wr_count) - CNT_BITS'(rd_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage; the extra item lands right after the main one
   always_ff @(posedge clock) begin
      if (wr_main) begin
         mem_ff[wr_ptr_ff] <= wr_data_main;
      end
      if (wr_extra) begin
         mem_ff[wr_ptr_plus1] <= wr_data_extra;
      end
   end

endmodule
